@@ src/tcw_pkg.sv @@
// ============================================================================
// tcw_pkg - shared types and constants of the text console writer
// Request/response payloads, command codes handed from the front end to the
// back end, character codes and default screen geometry.
// ============================================================================
package tcw_pkg;

    // default screen geometry
    localparam int DEF_COLUMNS = 80;
    localparam int DEF_LINES   = 25;

    // cursor position field width (position is reported modulo 2**POS_W)
    localparam int POS_W = 11;

    // command queue depth between front and back end
    localparam int QUEUE_DEPTH = 2;

    // attribute byte after reset: light grey on black
    localparam logic [7:0] ATTR_RESET = 8'h07;

    // request operations
    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // control characters
    localparam logic [7:0] CHAR_NUL       = 8'h00;
    localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
    localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;

    // command kinds decided by the front end
    localparam logic [1:0] CMD_NOP     = 2'd0; // report cursor, cell word zero
    localparam logic [1:0] CMD_READ    = 2'd1; // read one in-range cell
    localparam logic [1:0] CMD_CHAR    = 2'd2; // store character, advance
    localparam logic [1:0] CMD_NEWLINE = 2'd3; // next line, column zero

    typedef logic [7:0] attr_t;

    typedef struct packed {
        logic       operation;
        logic [7:0] char_code;
        logic [4:0] read_row;
        logic [6:0] read_col;
    } req_t;

    typedef struct packed {
        logic [15:0]      cell_word;
        logic [POS_W-1:0] linear_cursor;
    } rsp_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] char_code;
        logic [4:0] read_row;
        logic [6:0] read_col;
    } cmd_t;

    typedef struct packed {
        logic clearing;   // post-reset screen clear in progress
        logic scrolling;  // row copy / bottom row zeroing in progress
    } back_status_t;

endpackage

@@ src/tcw_chan_if.sv @@
// ============================================================================
// tcw_chan_if - valid/ready channel
// One request moves when valid and ready are both high at a rising edge.
// ============================================================================
interface tcw_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ src/tcw_ram.sv @@
// ============================================================================
// tcw_ram - generic simple dual-port RAM
// One write port, one read port, registered read data (old data on a
// same-address collision).
// ============================================================================
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ src/tcw_front.sv @@
// ============================================================================
// tcw_front - request classifier
// Turns each accepted request into a back-end command; range-checks reads.
// ============================================================================
module tcw_front #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int LINES   = tcw_pkg::DEF_LINES
) (
    input  logic          req_valid,
    input  tcw_pkg::req_t req_data,
    output logic          req_ready,
    input  logic          queue_full,
    input  logic          clearing,
    output logic          push,
    output tcw_pkg::cmd_t cmd
);
    import tcw_pkg::*;

    logic row_ok;
    logic col_ok;

    assign req_ready = !queue_full && !clearing;
    assign push      = req_valid && req_ready;

    assign row_ok = {27'd0, req_data.read_row} < 32'(LINES);
    assign col_ok = {25'd0, req_data.read_col} < 32'(COLUMNS);

    always_comb
    begin
        cmd.char_code = req_data.char_code;
        cmd.read_row  = req_data.read_row;
        cmd.read_col  = req_data.read_col;
        if (req_data.operation == OP_READ)
        begin
            // out-of-range reads just report zero
            cmd.kind = (row_ok && col_ok) ? CMD_READ : CMD_NOP;
        end
        else
        begin
            unique case (req_data.char_code)
                CHAR_NEWLINE:   cmd.kind = CMD_NEWLINE;
                CHAR_BACKSPACE: cmd.kind = CMD_NOP;
                CHAR_NUL:       cmd.kind = CMD_NOP;
                default:        cmd.kind = CMD_CHAR;
            endcase
        end
    end
endmodule

@@ src/tcw_queue.sv @@
// ============================================================================
// tcw_queue - command queue
// Short FIFO decoupling the classifier from the screen engine.
// ============================================================================
module tcw_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  tcw_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output tcw_pkg::cmd_t head_cmd
);
    import tcw_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    cmd_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = count_reg == FULL_CNT;
    assign head_valid = count_reg != '0;
    assign head_cmd   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end
endmodule

@@ src/tcw_back.sv @@
// ============================================================================
// tcw_back - screen engine
// Owns the cursor, the screen RAM and the response register; runs the
// post-reset clear, character stores, reads and the scroll sweep.
// ============================================================================
module tcw_back #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int LINES   = tcw_pkg::DEF_LINES
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tcw_pkg::attr_t        attr,
    input  logic                  cmd_valid,
    input  tcw_pkg::cmd_t         cmd,
    output logic                  cmd_pop,
    output logic                  rsp_valid,
    output tcw_pkg::rsp_t         rsp_data,
    input  logic                  rsp_ready,
    output tcw_pkg::back_status_t status
);
    import tcw_pkg::*;

    localparam int CELLS  = COLUMNS * LINES;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(COLUMNS);

    localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] LAST_BASE = ADDR_W'((LINES - 1) * COLUMNS);
    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
    localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_SCROLL = 3'd3;
    localparam logic [2:0] S_FLUSH  = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [ADDR_W-1:0] scan_reg, scan_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ADDR_W-1:0] base_reg, base_next;      // cursor row * COLUMNS
    logic              pend_reg, pend_next;      // scroll write pending, issued in the cycle after its read
    logic              pend_zero_reg, pend_zero_next;
    logic [ADDR_W-1:0] pend_addr_reg, pend_addr_next;
    logic              out_valid_reg, out_valid_next;
    rsp_t              out_data_reg, out_data_next;

    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [15:0]       wdata;
    logic [ADDR_W-1:0] raddr;
    logic [15:0]       rdata;

    logic                    slot_free;
    logic                    load;
    logic [15:0]             load_cell;
    logic [ADDR_W-1:0]       rd_lin;
    logic [ADDR_W-1:0]       cursor_lin;
    logic [ADDR_W+POS_W-1:0] pos_ext;

    tcw_ram #(
        .WIDTH (16),
        .DEPTH (CELLS)
    ) u_screen (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign slot_free  = !out_valid_reg || rsp_ready;
    assign rd_lin     = ADDR_W'(ADDR_W'(cmd.read_row) * COLS_A + ADDR_W'(cmd.read_col));
    // position reported after the command: taken from the next cursor
    assign cursor_lin = ADDR_W'(base_next + ADDR_W'(col_next));
    assign pos_ext    = {POS_W'(0), cursor_lin};

    always_comb
    begin
        state_next     = state_reg;
        scan_next      = scan_reg;
        col_next       = col_reg;
        base_next      = base_reg;
        pend_next      = pend_reg;
        pend_zero_next = pend_zero_reg;
        pend_addr_next = pend_addr_reg;
        cmd_pop        = 1'b0;
        we             = 1'b0;
        waddr          = pend_addr_reg;
        wdata          = pend_zero_reg ? 16'h0000 : rdata;
        raddr          = '0;
        load           = 1'b0;
        load_cell      = 16'h0000;

        unique case (state_reg)
            S_CLEAR:
            begin
                we    = 1'b1;
                waddr = scan_reg;
                wdata = 16'h0000;
                if (scan_reg == LAST_CELL)
                begin
                    scan_next  = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                raddr = rd_lin;
                if (cmd_valid && slot_free)
                begin
                    cmd_pop = 1'b1;
                    unique case (cmd.kind)
                        CMD_NOP:
                        begin
                            load = 1'b1;
                        end
                        CMD_READ:
                        begin
                            state_next = S_READ;
                        end
                        CMD_CHAR:
                        begin
                            we    = 1'b1;
                            waddr = ADDR_W'(base_reg + ADDR_W'(col_reg));
                            wdata = {attr, cmd.char_code};
                            if (col_reg != LAST_COL)
                            begin
                                col_next = col_reg + 1'b1;
                                load     = 1'b1;
                            end
                            else if (base_reg != LAST_BASE)
                            begin
                                col_next  = '0;
                                base_next = base_reg + COLS_A;
                                load      = 1'b1;
                            end
                            else
                            begin
                                col_next   = '0;
                                scan_next  = '0;
                                state_next = S_SCROLL;
                            end
                        end
                        CMD_NEWLINE:
                        begin
                            col_next = '0;
                            if (base_reg != LAST_BASE)
                            begin
                                base_next = base_reg + COLS_A;
                                load      = 1'b1;
                            end
                            else
                            begin
                                scan_next  = '0;
                                state_next = S_SCROLL;
                            end
                        end
                    endcase
                end
            end
            S_READ:
            begin
                load       = 1'b1;
                load_cell  = rdata;
                state_next = S_IDLE;
            end
            S_SCROLL:
            begin
                // read one row below, write it back in the cycle after;
                // bottom row destinations get zero
                raddr          = ADDR_W'(scan_reg + COLS_A);
                we             = pend_reg;
                pend_next      = 1'b1;
                pend_addr_next = scan_reg;
                pend_zero_next = scan_reg >= LAST_BASE;
                if (scan_reg == LAST_CELL)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            S_FLUSH:
            begin
                we         = pend_reg;
                pend_next  = 1'b0;
                scan_next  = '0;
                load       = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg && !rsp_ready;
        out_data_next  = out_data_reg;
        if (load)
        begin
            out_valid_next              = 1'b1;
            out_data_next.cell_word     = load_cell;
            out_data_next.linear_cursor = pos_ext[POS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            scan_reg      <= '0;
            col_reg       <= '0;
            base_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_reg      <= scan_next;
            col_reg       <= col_next;
            base_reg      <= base_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_zero_reg <= pend_zero_next;
        pend_addr_reg <= pend_addr_next;
        out_data_reg  <= out_data_next;
    end

    assign rsp_valid        = out_valid_reg;
    assign rsp_data         = out_data_reg;
    assign status.clearing  = state_reg == S_CLEAR;
    assign status.scrolling = (state_reg == S_SCROLL) || (state_reg == S_FLUSH);
endmodule

@@ src/text_console_writer.sv @@
// ============================================================================
// text_console_writer - text-mode console engine
// Screen store of LINES x COLUMNS 16-bit cells (attribute:character) with a
// cursor; puts characters with wrap and scroll, reads single cells.
// ============================================================================
//
//  Channel | Dir | Payload                                  | Notes
//  --------+-----+------------------------------------------+----------------------
//  req     | in  | operation, char_code, read_row, read_col | one request per item
//  rsp     | out | cell_word, cursor_pos                    | one per request
//  cfg     | in  | text_attribute (8 bits)                  | always ready
//
//  After reset the screen RAM is cleared, one cell a cycle; req.ready stays
//  low until every cell is cleared. The back end takes a put, newline or
//  no-op in its idle state, a read through the read state, and a put or
//  newline that scrolls through a sweep of every cell over the single screen
//  RAM write port and a flush state. The front end is combinational; the queue is registered.
//  A stalled rsp holds the response register; the queue still takes up to
//  two more requests, and the back end waits until the register is free.
//
module text_console_writer #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int LINES   = tcw_pkg::DEF_LINES
) (
    input  logic        clk,
    input  logic        rst_n,
    tcw_chan_if.sink    req,
    tcw_chan_if.source  rsp,
    tcw_chan_if.sink    cfg
);
    import tcw_pkg::*;

    // configuration: attribute byte for stored characters
    attr_t attr_reg;
    attr_t attr_next;

    // front end -> queue
    logic  push;
    cmd_t  push_cmd;
    logic  queue_full;

    // queue -> back end
    logic  head_valid;
    cmd_t  head_cmd;
    logic  pop;

    back_status_t back_status;
    logic         req_ready_w;
    logic         rsp_valid_w;
    rsp_t         rsp_data_w;

    assign cfg.ready = 1'b1;
    assign attr_next = cfg.valid ? attr_t'(cfg.data) : attr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg <= ATTR_RESET;
        end
        else
        begin
            attr_reg <= attr_next;
        end
    end

    // classify requests; blocked while the screen clear runs
    tcw_front #(
        .COLUMNS (COLUMNS),
        .LINES   (LINES)
    ) u_front (
        .req_valid  (req.valid),
        .req_data   (req.data),
        .req_ready  (req_ready_w),
        .queue_full (queue_full),
        .clearing   (back_status.clearing),
        .push       (push),
        .cmd        (push_cmd)
    );

    assign req.ready = req_ready_w;

    tcw_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // cursor, screen RAM and response register
    tcw_back #(
        .COLUMNS (COLUMNS),
        .LINES   (LINES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .attr      (attr_reg),
        .cmd_valid (head_valid),
        .cmd       (head_cmd),
        .cmd_pop   (pop),
        .rsp_valid (rsp_valid_w),
        .rsp_data  (rsp_data_w),
        .rsp_ready (rsp.ready),
        .status    (back_status)
    );

    assign rsp.valid = rsp_valid_w;
    assign rsp.data  = rsp_data_w;

    // no request enters while the screen is being cleared
    a_no_req_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n)
        back_status.clearing |-> !req.ready
    ) else $error("request accepted during screen clear");

    // the clear pass runs once after reset only
    a_clear_once: assert property (
        @(posedge clk) disable iff (!rst_n)
        !back_status.clearing |=> !back_status.clearing
    ) else $error("screen clear restarted");

    // the back end takes no command in the middle of a scroll
    a_no_pop_in_scroll: assert property (
        @(posedge clk) disable iff (!rst_n)
        back_status.scrolling |-> !pop
    ) else $error("command popped during scroll");

    // the queue is never pushed while full
    a_no_overflow: assert property (
        @(posedge clk) disable iff (!rst_n)
        queue_full |-> !push
    ) else $error("command queue overflow");
endmodule

@@ test/text_console_writer_checker.sv @@
`timescale 1ns / 1ps
// ============================================================================
// text_console_writer_checker - response predictor and comparator
// Watches the request, response and attribute channels. Keeps its own screen,
// cursor and attribute, predicts each response and compares it field by field.
// ============================================================================
module text_console_writer_checker #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int LINES   = tcw_pkg::DEF_LINES
) (
    input  logic clk,
    input  logic rst_n,
    tcw_chan_if  req,
    tcw_chan_if  rsp,
    tcw_chan_if  cfg,
    output int   fail_count,
    output int   pending
);
    import tcw_pkg::*;

    localparam int CELLS = COLUMNS * LINES;

    logic [15:0] screen [CELLS];
    logic [6:0]  cur_col;
    logic [4:0]  cur_row;
    attr_t       attribute;
    rsp_t        predicted_rsp [$];
    int          mismatches  = 0;
    int          outstanding = 0;

    assign fail_count = mismatches;
    assign pending    = outstanding;

    task automatic report_mismatch(string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // wrap past the last column, scroll everything up past the last line
    function automatic void wrap_and_scroll();
        if (int'(cur_col) > COLUMNS - 1)
        begin
            cur_col = '0;
            cur_row = cur_row + 1'b1;
        end
        if (int'(cur_row) >= LINES)
        begin
            for (int i = COLUMNS; i < CELLS; i++)
                screen[i - COLUMNS] = screen[i];
            for (int i = CELLS - COLUMNS; i < CELLS; i++)
                screen[i] = '0;
            cur_row = 5'(LINES - 1);
        end
    endfunction

    function automatic rsp_t apply_request(req_t r);
        rsp_t res;
        int   idx;
        res = '0;
        if (r.operation == OP_READ)
        begin
            if (int'(r.read_row) < LINES && int'(r.read_col) < COLUMNS)
                res.cell_word = screen[int'(r.read_row) * COLUMNS + int'(r.read_col)];
        end
        else if (r.char_code == CHAR_NEWLINE)
        begin
            cur_row = cur_row + 1'b1;
            cur_col = '0;
            wrap_and_scroll();
        end
        else if (r.char_code != CHAR_BACKSPACE && r.char_code != CHAR_NUL)
        begin
            idx = int'(cur_row) * COLUMNS + int'(cur_col);
            if (idx < CELLS)
                screen[idx] = {attribute, r.char_code};
            cur_col = cur_col + 1'b1;
            wrap_and_scroll();
        end
        res.linear_cursor = POS_W'(int'(cur_row) * COLUMNS + int'(cur_col));
        return res;
    endfunction

    task automatic check_response(rsp_t got);
        rsp_t want;
        if (predicted_rsp.size() == 0)
        begin
            report_mismatch($sformatf("response cell 0x%04h pos %0d with no request open",
                                      got.cell_word, got.linear_cursor));
            return;
        end
        want = predicted_rsp.pop_front();
        if (got.cell_word !== want.cell_word)
            report_mismatch($sformatf("cell_word got 0x%04h expected 0x%04h",
                                      got.cell_word, want.cell_word));
        if (got.linear_cursor !== want.linear_cursor)
            report_mismatch($sformatf("linear_cursor got %0d expected %0d",
                                      got.linear_cursor, want.linear_cursor));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CELLS; i++)
                screen[i] = '0;
            cur_col   = '0;
            cur_row   = '0;
            attribute = ATTR_RESET;
            predicted_rsp.delete();
            outstanding = 0;
        end
        else
        begin
            // a response never belongs to a request taken at the same edge
            if (rsp.valid && rsp.ready)
                check_response(rsp.data);
            if (cfg.valid && cfg.ready)
                attribute = cfg.data;
            if (req.valid && req.ready)
                predicted_rsp.push_back(apply_request(req.data));
            outstanding = predicted_rsp.size();
        end
    end

endmodule

@@ test/text_console_writer_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// text_console_writer_tb - testbench top for the text console writer
// Drives requests and attribute writes, stalls the response side at random,
// and lets the checker predict and compare every response. A directed opener
// covers control characters, byte extremes and out-of-range reads; random
// text lines then fill the screen, wrap and scroll it under four idle mixes.
// ============================================================================
module text_console_writer_tb;
    import tcw_pkg::*;

    // longest single request: a put that scrolls the whole screen
    localparam int SCROLL_CYCLES = DEF_COLUMNS * DEF_LINES + 2;

    logic clk;
    logic rst_n;
    int   send_idle_pct = 0;   // chance per cycle that the sender holds off
    int   rsp_stall_pct = 0;   // chance per cycle that the receiver stalls
    int   items_sent    = 0;   // requests that do real work (NUL/BS not counted)
    int   fail_count;
    int   pending;

    tcw_chan_if #(.payload_t(req_t))  req ();
    tcw_chan_if #(.payload_t(rsp_t))  rsp ();
    tcw_chan_if #(.payload_t(attr_t)) cfg ();

    text_console_writer #(
        .COLUMNS (DEF_COLUMNS),
        .LINES   (DEF_LINES)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    text_console_writer_checker #(
        .COLUMNS (DEF_COLUMNS),
        .LINES   (DEF_LINES)
    ) console_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .cfg        (cfg),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // 4 ns clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // hard stop in case the block hangs; real runs take well under a tenth of this
    initial
    begin
        #200_000_000;
        $display("text_console_writer test failed");
        $finish;
    end

    // response side: ready changes on the falling edge only
    initial
    begin
        rsp.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp.ready <= ($urandom_range(99) >= rsp_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // request helpers
    // ------------------------------------------------------------------------

    // put request; the unused read fields still get random bits
    function automatic req_t put_req(logic [7:0] ch);
        req_t r;
        r.operation = OP_PUT;
        r.char_code = ch;
        r.read_row  = 5'($urandom_range(31));
        r.read_col  = 7'($urandom_range(127));
        return r;
    endfunction

    // read request; char_code is ignored by the block, so randomize it
    function automatic req_t read_req(int row, int col);
        req_t r;
        r.operation = OP_READ;
        r.char_code = 8'($urandom_range(255));
        r.read_row  = 5'(row);
        r.read_col  = 7'(col);
        return r;
    endfunction

    // mostly in-range reads, biased toward the left where short lines live;
    // about one in five lands outside the screen
    function automatic req_t random_read();
        unique case ($urandom_range(9))
            0: return read_req($urandom_range(31, DEF_LINES), $urandom_range(127));
            1: return read_req($urandom_range(DEF_LINES - 1),
                               $urandom_range(127, DEF_COLUMNS));
            default:
            begin
                if ($urandom_range(1))
                    return read_req($urandom_range(DEF_LINES - 1),
                                    $urandom_range(DEF_COLUMNS - 1));
                return read_req($urandom_range(DEF_LINES - 1), $urandom_range(20));
            end
        endcase
    endfunction

    // mostly printable text, now and then any byte (control codes, high bytes)
    function automatic logic [7:0] text_char();
        if ($urandom_range(99) < 85)
            return 8'($urandom_range(126, 32));
        return 8'($urandom_range(255));
    endfunction

    // present one request at the falling edge, wait for the handshake;
    // valid stays high into the next request unless the sender idles
    task automatic send_request(req_t r);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid <= 1'b1;
        req.data  <= r;
        do
            @(posedge clk);
        while (!req.ready);
        if (r.operation == OP_READ ||
            (r.char_code != CHAR_NUL && r.char_code != CHAR_BACKSPACE))
            items_sent++;
    endtask

    // stop sending and wait until every predicted response has come back
    task automatic drain_responses();
        @(negedge clk);
        req.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // attribute write; only called with the block idle
    task automatic write_attribute(attr_t value);
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.data  <= value;
        do
            @(posedge clk);
        while (!cfg.ready);
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    // random traffic: text lines (some long enough to wrap), read bursts and
    // a little noise with every field random. Halfway through, the sender
    // waits for the response queue to run dry once.
    task automatic run_traffic(int count);
        int stop_at;
        int pause_at;
        int pick;
        int len;
        bit paused;
        stop_at  = items_sent + count;
        pause_at = items_sent + count / 2;
        paused   = 1'b0;
        while (items_sent < stop_at)
        begin
            if (!paused && items_sent >= pause_at)
            begin
                drain_responses();
                paused = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 60)
            begin
                if ($urandom_range(7) == 0)
                    len = $urandom_range(170, 60);
                else
                    len = $urandom_range(40, 1);
                repeat (len)
                    send_request(put_req(text_char()));
                if ($urandom_range(1))
                    send_request(put_req(CHAR_NEWLINE));
            end
            else if (pick < 90)
            begin
                repeat ($urandom_range(6, 1))
                    send_request(random_read());
            end
            else
            begin
                req_t r;
                r.operation = 1'($urandom_range(1));
                r.char_code = 8'($urandom_range(255));
                r.read_row  = 5'($urandom_range(31));
                r.read_col  = 7'($urandom_range(127));
                send_request(r);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        attr_t phase_attr [4];
        int    phase_idle [4];
        int    phase_stall [4];

        rst_n     = 1'b0;
        req.valid = 1'b0;
        req.data  = '0;
        cfg.valid = 1'b0;
        cfg.data  = ATTR_RESET;

        // attribute extremes first, then two random values
        phase_attr  = '{8'hFF, 8'h00, 8'($urandom_range(254, 1)), 8'($urandom_range(255))};
        // no idling, sender idle, receiver stalls, both
        phase_idle  = '{0, 55, 0, 24};
        phase_stall = '{0, 0, 55, 24};

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed opener, reset attribute; ready stays low while the
        // screen is cleared, the handshake simply waits it out
        send_request(read_req(0, 0));                 // cleared screen reads zero
        send_request(put_req(8'h41));
        send_request(put_req(8'hFF));                 // top byte value
        send_request(put_req(8'h80));                 // high bytes stored as-is
        send_request(put_req(8'h01));
        send_request(put_req(CHAR_NUL));              // ignored
        send_request(put_req(CHAR_BACKSPACE));        // cursor stays put
        for (int c = 0; c < 5; c++)
            send_request(read_req(0, c));
        send_request(read_req(31, 127));              // both coordinates out of range
        send_request(read_req(DEF_LINES, 0));         // first row past the screen
        send_request(read_req(0, DEF_COLUMNS));       // first column past the screen
        send_request(read_req(DEF_LINES - 1, DEF_COLUMNS - 1));
        send_request(put_req(CHAR_NEWLINE));
        send_request(put_req(8'h7E));
        send_request(read_req(1, 0));
        send_request(read_req(0, 3));

        for (int phase = 0; phase < 4; phase++)
        begin
            // attribute only changes with nothing in flight
            drain_responses();
            repeat (8) @(negedge clk);
            write_attribute(phase_attr[phase]);
            send_idle_pct = phase_idle[phase];
            rsp_stall_pct = phase_stall[phase];
            run_traffic(500);
        end

        drain_responses();
        // give a stray late response time to show up
        repeat (SCROLL_CYCLES) @(negedge clk);

        if (fail_count == 0)
            $display("text_console_writer test passed");
        else
            $display("text_console_writer test failed");
        $finish;
    end

endmodule
